/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the scaler checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is active.
`define BIS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BIS_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/bis_pkg.sv */
// ----------------------------------------------------------------------------
// Bilinear scaler package
// Field widths, operation and register codes, and the payload structs.
// ----------------------------------------------------------------------------
package bis_pkg;

	localparam int COORD_W    = 10;
	localparam int CHAN_W     = 8;
	localparam int PIXEL_W    = 4 * CHAN_W;
	localparam int STEP_W     = 24;
	localparam int SIZE_W     = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int FRAC_W     = 16;
	localparam int POS_W      = COORD_W + STEP_W;
	localparam int INT_W      = POS_W - FRAC_W;

	typedef enum logic {
		OP_WRITE   = 1'b0,
		OP_REQUEST = 1'b1
	} op_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_X     = 2'd0,
		REG_STEP_Y     = 2'd1,
		REG_SRC_WIDTH  = 2'd2,
		REG_SRC_HEIGHT = 2'd3
	} reg_idx_e;

	typedef struct packed {
		op_e               op;
		logic [COORD_W-1:0] coord_x;
		logic [COORD_W-1:0] coord_y;
		logic [CHAN_W-1:0]  in_red;
		logic [CHAN_W-1:0]  in_green;
		logic [CHAN_W-1:0]  in_blue;
		logic [CHAN_W-1:0]  in_alpha;
	} bis_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic [CHAN_W-1:0] out_alpha;
	} bis_out_t;

	typedef struct packed {
		logic [STEP_W-1:0] step_x;
		logic [STEP_W-1:0] step_y;
		logic [SIZE_W-1:0] src_width;
		logic [SIZE_W-1:0] src_height;
	} bis_cfg_t;

	typedef struct packed {
		logic valid;
		logic request;
		logic col_a_odd;
		logic col_b_odd;
		logic row_a_odd;
		logic row_b_odd;
	} bis_tap_t;

endpackage

/* rtl/bilinear_image_scaler_core.sv */
// ----------------------------------------------------------------------------
// Bilinear image scaler core
// Stores an RGBA8 source image in four parity banks and answers destination
// pixel requests by bilinear interpolation of the four source neighbours.
// ----------------------------------------------------------------------------
//  Channel  Signals                          Moves
//  cfg      cfg_we, cfg_index, cfg_wdata     register write, no handshake
//  in       in_valid, in_ready, in_data      pixel write or pixel request
//  out      out_valid, out_ready, out_data   interpolated pixel
//
// One transaction is accepted per cycle while the output is not stalled; a
// request's result is registered through the five register stages (product,
// address, bank read with weights, channel products, sum).
// The whole pipeline advances together and holds while a result waits.
// Reset clears the valid bits and returns the configuration registers to
// their defaults; image contents are undefined until written.
// ----------------------------------------------------------------------------
module bilinear_image_scaler_core
	import bis_pkg::*;
#(
	parameter int MAX_SRC_WIDTH    = 256,
	parameter int MAX_SRC_HEIGHT   = 256,
	parameter int WEIGHT_FRAC_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  bis_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output bis_out_t              out_data
);

	localparam int XW  = $clog2(MAX_SRC_WIDTH);
	localparam int YW  = $clog2(MAX_SRC_HEIGHT);
	localparam int HXW = (XW > 1) ? XW - 1 : 1;
	localparam int HYW = (YW > 1) ? YW - 1 : 1;
	localparam int AW  = HXW + HYW;

	bis_cfg_t                    cfg_q;
	logic                        adv;
	bis_tap_t                    tap_s2;
	logic [WEIGHT_FRAC_BITS-1:0] fx_s2;
	logic [WEIGHT_FRAC_BITS-1:0] fy_s2;
	logic [3:0][AW-1:0]          bank_addr_s2;
	logic [3:0]                  bank_we_s2;
	logic [PIXEL_W-1:0]          wdata_s2;
	logic [3:0][PIXEL_W-1:0]     rdata_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_x     <= '0;
			cfg_q.step_y     <= '0;
			cfg_q.src_width  <= SIZE_W'(256);
			cfg_q.src_height <= SIZE_W'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEP_X:     cfg_q.step_x     <= cfg_wdata[STEP_W-1:0];
				REG_STEP_Y:     cfg_q.step_y     <= cfg_wdata[STEP_W-1:0];
				REG_SRC_WIDTH:  cfg_q.src_width  <= cfg_wdata[SIZE_W-1:0];
				REG_SRC_HEIGHT: cfg_q.src_height <= cfg_wdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	bis_addr #(
		.MAX_SRC_WIDTH    (MAX_SRC_WIDTH),
		.MAX_SRC_HEIGHT   (MAX_SRC_HEIGHT),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_addr (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_valid     (in_valid),
		.in_data      (in_data),
		.cfg          (cfg_q),
		.tap_s2       (tap_s2),
		.fx_s2        (fx_s2),
		.fy_s2        (fy_s2),
		.bank_addr_s2 (bank_addr_s2),
		.bank_we_s2   (bank_we_s2),
		.wdata_s2     (wdata_s2)
	);

	for (genvar b = 0; b < 4; b++) begin : g_bank
		bis_bank #(
			.AW (AW)
		) u_bank (
			.clk      (clk),
			.en       (adv),
			.we       (bank_we_s2[b]),
			.addr     (bank_addr_s2[b]),
			.wdata    (wdata_s2),
			.rdata_s3 (rdata_s3[b])
		);
	end

	bis_blend #(
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.tap_s2    (tap_s2),
		.fx_s2     (fx_s2),
		.fy_s2     (fy_s2),
		.rdata_s3  (rdata_s3),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

/* rtl/bis_addr.sv */
// ----------------------------------------------------------------------------
// Bilinear scaler address stages
// Forms the source position, clamps the four neighbours to the image and
// maps them, or a pixel write, onto the four parity banks.
// ----------------------------------------------------------------------------
module bis_addr
	import bis_pkg::*;
#(
	parameter int MAX_SRC_WIDTH    = 256,
	parameter int MAX_SRC_HEIGHT   = 256,
	parameter int WEIGHT_FRAC_BITS = 8,
	localparam int XW  = $clog2(MAX_SRC_WIDTH),
	localparam int YW  = $clog2(MAX_SRC_HEIGHT),
	localparam int HXW = (XW > 1) ? XW - 1 : 1,
	localparam int HYW = (YW > 1) ? YW - 1 : 1,
	localparam int AW  = HXW + HYW
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic                               in_valid,
	input  bis_in_t                            in_data,
	input  bis_cfg_t                           cfg,
	output bis_tap_t                           tap_s2,
	output logic [WEIGHT_FRAC_BITS-1:0]        fx_s2,
	output logic [WEIGHT_FRAC_BITS-1:0]        fy_s2,
	output logic [3:0][AW-1:0]                 bank_addr_s2,
	output logic [3:0]                         bank_we_s2,
	output logic [PIXEL_W-1:0]                 wdata_s2
);

	localparam int LIM_W = INT_W + 1;

	logic                valid_s1;
	bis_in_t             item_s1;
	logic [POS_W-1:0]    pos_x_s1;
	logic [POS_W-1:0]    pos_y_s1;

	logic [LIM_W-1:0]    wlim;
	logic [LIM_W-1:0]    hlim;
	logic [LIM_W-1:0]    x1e;
	logic [LIM_W-1:0]    y1e;
	logic [LIM_W-1:0]    x1p;
	logic [LIM_W-1:0]    y1p;
	logic [LIM_W-1:0]    xa_w;
	logic [LIM_W-1:0]    xb_w;
	logic [LIM_W-1:0]    ya_w;
	logic [LIM_W-1:0]    yb_w;
	logic [XW-1:0]       xa;
	logic [XW-1:0]       xb;
	logic [YW-1:0]       ya;
	logic [YW-1:0]       yb;
	logic [XW-1:0]       xa_h;
	logic [XW-1:0]       xb_h;
	logic [YW-1:0]       ya_h;
	logic [YW-1:0]       yb_h;
	logic [1:0][HXW-1:0] col_half;
	logic [1:0][HYW-1:0] row_half;
	logic [XW-1:0]       wx;
	logic [YW-1:0]       wy;
	logic [XW-1:0]       wx_h;
	logic [YW-1:0]       wy_h;
	logic [AW-1:0]       w_addr;
	logic [1:0]          w_bank;
	logic                w_in;
	logic                is_write;
	logic [3:0][AW-1:0]  addr_nx;
	logic [3:0]          we_nx;
	bis_tap_t            tap_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1  <= in_data;
			pos_x_s1 <= POS_W'(in_data.coord_x) * POS_W'(cfg.step_x);
			pos_y_s1 <= POS_W'(in_data.coord_y) * POS_W'(cfg.step_y);
		end
	end

	always_comb begin
		if (cfg.src_width == '0) begin
			wlim = '0;
		end else if (32'(cfg.src_width) > MAX_SRC_WIDTH) begin
			wlim = LIM_W'(MAX_SRC_WIDTH - 1);
		end else begin
			wlim = LIM_W'(cfg.src_width) - LIM_W'(1);
		end
		if (cfg.src_height == '0) begin
			hlim = '0;
		end else if (32'(cfg.src_height) > MAX_SRC_HEIGHT) begin
			hlim = LIM_W'(MAX_SRC_HEIGHT - 1);
		end else begin
			hlim = LIM_W'(cfg.src_height) - LIM_W'(1);
		end
	end

	always_comb begin
		x1e  = {1'b0, pos_x_s1[POS_W-1:FRAC_W]};
		y1e  = {1'b0, pos_y_s1[POS_W-1:FRAC_W]};
		x1p  = x1e + LIM_W'(1);
		y1p  = y1e + LIM_W'(1);
		xa_w = (x1e > wlim) ? wlim : x1e;
		xb_w = (x1p > wlim) ? wlim : x1p;
		ya_w = (y1e > hlim) ? hlim : y1e;
		yb_w = (y1p > hlim) ? hlim : y1p;
		xa   = xa_w[XW-1:0];
		xb   = xb_w[XW-1:0];
		ya   = ya_w[YW-1:0];
		yb   = yb_w[YW-1:0];
		xa_h = xa >> 1;
		xb_h = xb >> 1;
		ya_h = ya >> 1;
		yb_h = yb >> 1;

		// Each parity bank serves whichever neighbour falls on its parity.
		col_half[0] = xa[0] ? xb_h[HXW-1:0] : xa_h[HXW-1:0];
		col_half[1] = xa[0] ? xa_h[HXW-1:0] : xb_h[HXW-1:0];
		row_half[0] = ya[0] ? yb_h[HYW-1:0] : ya_h[HYW-1:0];
		row_half[1] = ya[0] ? ya_h[HYW-1:0] : yb_h[HYW-1:0];

		wx       = XW'(item_s1.coord_x);
		wy       = YW'(item_s1.coord_y);
		wx_h     = wx >> 1;
		wy_h     = wy >> 1;
		w_addr   = {wy_h[HYW-1:0], wx_h[HXW-1:0]};
		w_bank   = {wy[0], wx[0]};
		w_in     = (32'(item_s1.coord_x) < MAX_SRC_WIDTH) &&
		           (32'(item_s1.coord_y) < MAX_SRC_HEIGHT);
		is_write = (item_s1.op == OP_WRITE);

		for (int b = 0; b < 4; b++) begin
			logic [1:0] bsel;
			bsel       = 2'(b);
			addr_nx[b] = is_write ? w_addr : {row_half[bsel[1]], col_half[bsel[0]]};
			we_nx[b]   = valid_s1 && is_write && w_in && (w_bank == bsel);
		end

		tap_nx.valid     = valid_s1;
		tap_nx.request   = (item_s1.op == OP_REQUEST);
		tap_nx.col_a_odd = xa[0];
		tap_nx.col_b_odd = xb[0];
		tap_nx.row_a_odd = ya[0];
		tap_nx.row_b_odd = yb[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s2     <= '0;
			bank_we_s2 <= '0;
		end else if (adv) begin
			tap_s2     <= tap_nx;
			bank_we_s2 <= we_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bank_addr_s2 <= addr_nx;
			fx_s2        <= pos_x_s1[FRAC_W-1 -: WEIGHT_FRAC_BITS];
			fy_s2        <= pos_y_s1[FRAC_W-1 -: WEIGHT_FRAC_BITS];
			wdata_s2     <= {item_s1.in_alpha, item_s1.in_blue,
			                 item_s1.in_green, item_s1.in_red};
		end
	end

endmodule

/* rtl/bis_bank.sv */
// ----------------------------------------------------------------------------
// Bilinear scaler pixel bank
// One parity bank of the source image: one write or read address per cycle
// while enabled, registered read data.
// ----------------------------------------------------------------------------
module bis_bank
	import bis_pkg::*;
#(
	parameter int AW = 14
) (
	input  logic               clk,
	input  logic               en,
	input  logic               we,
	input  logic [AW-1:0]      addr,
	input  logic [PIXEL_W-1:0] wdata,
	output logic [PIXEL_W-1:0] rdata_s3
);

	logic [PIXEL_W-1:0] mem_q [2**AW];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end
			rdata_s3 <= mem_q[addr];
		end
	end

endmodule

/* rtl/bis_blend.sv */
// ----------------------------------------------------------------------------
// Bilinear scaler blend stages
// Builds the four corner weights, weights each channel of the four
// neighbours and sums them into the truncated result pixel.
// ----------------------------------------------------------------------------
module bis_blend
	import bis_pkg::*;
#(
	parameter int WEIGHT_FRAC_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  bis_tap_t                    tap_s2,
	input  logic [WEIGHT_FRAC_BITS-1:0] fx_s2,
	input  logic [WEIGHT_FRAC_BITS-1:0] fy_s2,
	input  logic [3:0][PIXEL_W-1:0]     rdata_s3,
	output logic                        out_valid,
	output bis_out_t                    out_data
);

	localparam int F  = WEIGHT_FRAC_BITS;
	localparam int WW = 2 * F + 1;
	localparam int PW = CHAN_W + WW;
	localparam int SW = 2 * F + CHAN_W + 2;
	localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

	logic [F:0]                  fxe;
	logic [F:0]                  fye;
	logic [F:0]                  ofx;
	logic [F:0]                  ofy;
	logic [3:0][WW-1:0]          w_full;
	logic [3:0][WW-1:0]          w_s3;
	logic                        valid_s3;
	bis_tap_t                    tap_s3;
	logic [3:0][PIXEL_W-1:0]     nbr;
	logic [3:0][3:0][PW-1:0]     prod_nx;
	logic [3:0][3:0][PW-1:0]     prod_s4;
	logic                        valid_s4;
	logic [3:0][SW-1:0]          sum;
	logic [3:0][CHAN_W-1:0]      chan;
	logic                        valid_s5;
	bis_out_t                    out_s5;

	always_comb begin
		fxe       = {1'b0, fx_s2};
		fye       = {1'b0, fy_s2};
		ofx       = ONE - fxe;
		ofy       = ONE - fye;
		w_full[0] = WW'(ofx) * WW'(ofy);
		w_full[1] = WW'(fxe) * WW'(ofy);
		w_full[2] = WW'(ofx) * WW'(fye);
		w_full[3] = WW'(fxe) * WW'(fye);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= tap_s2.valid && tap_s2.request;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tap_s3 <= tap_s2;
			for (int k = 0; k < 4; k++) begin
				w_s3[k] <= w_full[k];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			logic [1:0] ksel;
			logic       c_odd;
			logic       r_odd;
			ksel   = 2'(k);
			c_odd  = ksel[0] ? tap_s3.col_b_odd : tap_s3.col_a_odd;
			r_odd  = ksel[1] ? tap_s3.row_b_odd : tap_s3.row_a_odd;
			nbr[k] = rdata_s3[{r_odd, c_odd}];
			for (int c = 0; c < 4; c++) begin
				prod_nx[k][c] = PW'(nbr[k][c*CHAN_W +: CHAN_W]) * PW'(w_s3[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s4 <= prod_nx;
		end
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			sum[c]  = SW'(prod_s4[0][c]) + SW'(prod_s4[1][c]) +
			          SW'(prod_s4[2][c]) + SW'(prod_s4[3][c]);
			chan[c] = sum[c][2*F +: CHAN_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s5.out_red   <= chan[0];
			out_s5.out_green <= chan[1];
			out_s5.out_blue  <= chan[2];
			out_s5.out_alpha <= chan[3];
		end
	end

	assign out_valid = valid_s5;
	assign out_data  = out_s5;

endmodule

/* rtl/bis_checker.sv */
// ----------------------------------------------------------------------------
// Bilinear scaler port checker
// Watches the top-level ports for reset, back-pressure and output holding.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bis_checker
	import bis_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input bis_out_t out_data
);

	logic out_stall;

	assign out_stall = out_valid && !out_ready;

	`BIS_ASSERT_ALWAYS(a_reset_no_out, clk, !arst_n |-> !out_valid, "result valid in reset")

	`BIS_ASSERT(a_ready_follows_out, clk, arst_n, in_ready == !out_stall, "input ready wrong")

	`BIS_ASSERT(a_out_holds, clk, arst_n, out_stall |=> out_valid && $stable(out_data), "result changed")

	`BIS_ASSERT(a_in_stall_cause, clk, arst_n, in_valid && !in_ready |-> out_stall, "input stalled")

endmodule

bind bilinear_image_scaler_core bis_checker u_bis_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
